// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the list block.
// Depends on clk and rst being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition and consequence checked on the same clock edge
`define CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list check failed");

// consequence checked on the following clock edge
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list check failed");

`endif

// ----- rtl/tknl_pkg.sv -----
// Package for the top-k neighbor list: field widths, codes and the
// command/status structs between controller and datapath. No dependencies.
package tknl_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS  = 32;

  localparam int MODE_W     = 2;
  localparam int ID_W       = 32;
  localparam int DIST_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 5;
  localparam int FILLED_W   = 6;
  localparam int CAP_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAPACITY_RST     = CAP_W'(32);
  localparam logic [DIST_W-1:0] START_RADIUS_RST = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_DUMP   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_BEYOND    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_CLEARED   = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY     = 2'd0,
    REG_START_RADIUS = 2'd1
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input channel ready
    logic eval;       // register compare results of all cells
    logic apply;      // shift/insert and set result code
    logic tail;       // reload bound from the last kept cell
    logic clear;      // empty the list
    logic load_res;   // load output register with the pending result
    logic dump_emit;  // load output register with one dump entry
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  in_valid;
    mode_t in_mode;
    logic  need_tail;
    logic  out_free;
    logic  dump_last;
  } dp_stat_t;

endpackage

// ----- rtl/tknl_ifs.sv -----
// Channel interfaces of the top-k neighbor list: candidate requests,
// result items and configuration writes. Depends on tknl_pkg.
interface tknl_cand_if import tknl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   cand_id;
  logic [DIST_W-1:0] cand_dist;

  modport source (output valid, mode, cand_id, cand_dist, input ready);
  modport sink   (input valid, mode, cand_id, cand_dist, output ready);
endinterface

interface tknl_result_if import tknl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [FILLED_W-1:0] filled;
  logic [DIST_W-1:0]   bound;
  logic [ID_W-1:0]     entry_id;
  logic [DIST_W-1:0]   entry_dist;
  logic                last;

  modport source (output valid, status, slot, filled, bound, entry_id, entry_dist, last,
                  input ready);
  modport sink   (input valid, status, slot, filled, bound, entry_id, entry_dist, last,
                  output ready);
endinterface

interface tknl_cfg_if import tknl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tknl_ctrl.sv -----
// Controller of the top-k neighbor list: sequences insert, clear and dump
// requests. Depends on tknl_pkg (command and status structs).
module tknl_ctrl import tknl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_APPLY = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_DUMP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          case (stat.in_mode)
            MODE_INSERT: state_next = S_EVAL;
            MODE_CLEAR:  state_next = S_CLEAR;
            MODE_DUMP:   state_next = S_DUMP;
            default:     state_next = S_IDLE;  // unused code: dropped
          endcase
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = stat.need_tail ? S_TAIL : S_EMIT;
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_EMIT;
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_emit = 1'b1;
          if (stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tknl_datapath.sv -----
// Datapath of the top-k neighbor list: config registers, the sorted row of
// compare-and-shift cells, fill/bound state and the output register. Uses tknl_pkg.
module tknl_datapath import tknl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic   clk,
  input  logic   rst,
  tknl_cand_if.sink     cand,
  tknl_result_if.source result,
  tknl_cfg_if.sink      cfg,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);

  // configuration registers
  logic [CAP_W-1:0]  capacity;
  logic [DIST_W-1:0] start_radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAPACITY_RST;
      start_radius <= START_RADIUS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_CAPACITY:     capacity     <= cfg.data[CAP_W-1:0];
        REG_START_RADIUS: start_radius <= cfg.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // capacity clamped to 1..CAPACITY
  logic [CNTW-1:0] eff_cap;
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNTW'(1);
    end else if (int'(capacity) > CAPACITY) begin
      eff_cap = CNTW'(CAPACITY);
    end else begin
      eff_cap = CNTW'(capacity);
    end
  end

  // request capture
  logic              accept;
  logic [ID_W-1:0]   cid;
  logic [DIST_W-1:0] cd;

  assign cand.ready    = cmd.take;
  assign accept        = cand.valid && cmd.take;
  assign stat.in_valid = cand.valid;
  assign stat.in_mode  = mode_t'(cand.mode);

  always_ff @(posedge clk) begin
    if (accept) begin
      cid <= cand.cand_id;
      cd  <= cand.cand_dist;
    end
  end

  // list cells
  logic [DIST_W-1:0] dists [CAPACITY];
  logic [ID_W-1:0]   ids   [CAPACITY];
  logic [CNTW-1:0]   fill;
  logic [DIST_W-1:0] bound;

  // per-cell compares: tvec marks cells at or after the insertion point
  logic [CAPACITY-1:0] valid_c, tvec_c, dupv_c, tvec, hit_v;
  logic                dup, beyond;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cmp
    assign valid_c[j] = CNTW'(j) < fill;
    assign tvec_c[j]  = !valid_c[j] || (dists[j] > cd);
    assign dupv_c[j]  = valid_c[j] && (dists[j] == cd) && (ids[j] == cid);
    if (j == 0) begin : g_first
      assign hit_v[j] = tvec[j];
    end else begin : g_rest
      assign hit_v[j] = tvec[j] && !tvec[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      tvec   <= tvec_c;
      dup    <= |dupv_c;
      beyond <= cd > bound;
    end
  end

  // insertion point from the single rising edge of tvec
  logic [IDXW-1:0] enc;
  logic [CNTW-1:0] ins_pos;
  logic            full, drop, ins_ok;

  always_comb begin
    enc = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (hit_v[j]) begin
        enc = enc | IDXW'(j);
      end
    end
  end

  assign ins_pos        = (|hit_v) ? CNTW'(enc) : fill;
  assign full           = (fill == eff_cap);
  assign drop           = full && (ins_pos == fill);
  assign ins_ok         = !beyond && !dup && !drop;
  assign stat.need_tail = !beyond && !dup && full;

  // shift row: new entry at the hit cell, later cells take their upper neighbor
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.apply && ins_ok) begin
        if (hit_v[j]) begin
          dists[j] <= cd;
          ids[j]   <= cid;
        end else if (j > 0 && tvec[(j > 0) ? j-1 : 0]) begin
          dists[j] <= dists[(j > 0) ? j-1 : 0];
          ids[j]   <= ids[(j > 0) ? j-1 : 0];
        end
      end
    end
  end

  // shared read port: tail reload or dump entry
  logic [IDXW-1:0]   dump_k;
  logic [CNTW-1:0]   fill_m1;
  logic [IDXW-1:0]   rd_addr;
  logic [DIST_W-1:0] rd_dist;
  logic [ID_W-1:0]   rd_id;

  assign fill_m1 = fill - CNTW'(1);
  assign rd_addr = cmd.tail ? fill_m1[IDXW-1:0] : dump_k;
  assign rd_dist = dists[rd_addr];
  assign rd_id   = ids[rd_addr];

  // fill count and bound
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      bound <= START_RADIUS_RST;
    end else begin
      if (accept && cand.mode == MODE_INSERT && fill > eff_cap) begin
        fill <= eff_cap;  // capacity was lowered: cut the list
      end
      if (cmd.clear) begin
        fill  <= '0;
        bound <= start_radius;
      end
      if (cmd.apply && ins_ok && !full) begin
        fill <= fill + CNTW'(1);
      end
      if (cmd.tail) begin
        bound <= rd_dist;
      end
    end
  end

  // pending result code
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (beyond) begin
        res_status <= ST_BEYOND;
        res_slot   <= '0;
      end else if (dup) begin
        res_status <= ST_DUPLICATE;
        res_slot   <= '0;
      end else if (drop) begin
        res_status <= ST_BEYOND;
        res_slot   <= '0;
      end else begin
        res_status <= ST_INSERTED;
        res_slot   <= SLOT_W'(ins_pos);
      end
    end else if (cmd.clear) begin
      res_status <= ST_CLEARED;
      res_slot   <= '0;
    end
  end

  // dump walk
  logic [CNTW-1:0] n_dump;
  logic            dump_none;

  assign n_dump         = (int'(fill) > MAX_RESULTS) ? CNTW'(MAX_RESULTS) : fill;
  assign dump_none      = (n_dump == '0);
  assign stat.dump_last = dump_none || ((CNTW'(dump_k) + CNTW'(1)) == n_dump);

  always_ff @(posedge clk) begin
    if (accept) begin
      dump_k <= '0;
    end else if (cmd.dump_emit) begin
      dump_k <= dump_k + IDXW'(1);
    end
  end

  // output register
  logic                out_valid;
  status_t             out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [FILLED_W-1:0] out_filled;
  logic [DIST_W-1:0]   out_bound;
  logic [ID_W-1:0]     out_id;
  logic [DIST_W-1:0]   out_dist;
  logic                out_last;

  assign stat.out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_res || cmd.dump_emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_filled <= FILLED_W'(fill);
      out_bound  <= bound;
      out_id     <= '0;
      out_dist   <= '0;
      out_last   <= 1'b1;
    end else if (cmd.dump_emit) begin
      out_filled <= FILLED_W'(fill);
      out_bound  <= bound;
      if (dump_none) begin
        out_status <= ST_EMPTY;
        out_slot   <= '0;
        out_id     <= '0;
        out_dist   <= '0;
        out_last   <= 1'b1;
      end else begin
        out_status <= ST_ENTRY;
        out_slot   <= SLOT_W'(dump_k);
        out_id     <= rd_id;
        out_dist   <= rd_dist;
        out_last   <= stat.dump_last;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.slot       = out_slot;
  assign result.filled     = out_filled;
  assign result.bound      = out_bound;
  assign result.entry_id   = out_id;
  assign result.entry_dist = out_dist;
  assign result.last       = out_last;

endmodule

// ----- rtl/top_k_neighbor_list.sv -----
// Top-k neighbor list. Insert: taken in IDLE, then EVAL and APPLY; EMIT loads the result
// into the output register. A full list adds TAIL before EMIT, unless the candidate is
// beyond the bound or a duplicate, to reload the bound from the last kept cell.
// Clear: CLEAR, then EMIT. Dump: one entry per cycle while the output register is free.
// Next request is taken after the result is loaded; a stalled output register holds it off.
// Sync reset: list empty, bound all ones, capacity 32; cell contents not reset.
`include "assert_macros.svh"

module top_k_neighbor_list import tknl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  tknl_cand_if.sink     cand,
  tknl_result_if.source result,
  tknl_cfg_if.sink      cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  tknl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // list storage and result path
  tknl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat)
  );

  // checks
  `CHK_NEXT(a_busy_after_take, cand.valid && cand.ready && cand.mode != MODE_UNUSED, !cand.ready)
  `CHK_SAME(a_single_is_last, result.valid && result.status != ST_ENTRY, result.last)
  `CHK_SAME(a_clear_empties, result.valid && result.status == ST_CLEARED, result.filled == '0)

endmodule

// ----- bench/tb_top.sv -----
// Testbench for top_k_neighbor_list: a directed table, then random phases,
// all checked against a sorted-list predictor. Depends on tknl_pkg and tknl_ifs.
module tb_top;
  import tknl_pkg::*;

  localparam int          RANDOM_ITEMS = 290;
  localparam int          SETTLE       = 8;
  localparam int          DRAIN        = 40;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          LIMIT        = 2000000;
  localparam logic [31:0] ALL1         = 32'hFFFF_FFFF;

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [FILLED_W-1:0] filled;
    logic [DIST_W-1:0] bound;
    logic [ID_W-1:0]   entry_id;
    logic [DIST_W-1:0] entry_dist;
    logic              last;
  } list_result_t;

  typedef struct {
    step_kind_t   kind;
    mode_t        mode;
    cfg_reg_t     reg_idx;
    logic [31:0]  id;
    logic [31:0]  cdist;  // also the write data of a register row
    bit           typed;
    list_result_t known;
  } plan_row_t;

  logic clk;
  logic rst;

  tknl_cand_if   cand_ch ();
  tknl_result_if res_ch ();
  tknl_cfg_if    cfg_ch ();

  top_k_neighbor_list #(.CAPACITY(CAPACITY_DEF)) uut (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // predictor state: register copies and the sorted list
  logic [CAP_W-1:0]  reg_capacity;
  logic [DIST_W-1:0] reg_radius;
  logic [ID_W-1:0]   nl_ids   [0:CAPACITY_DEF-1];
  logic [DIST_W-1:0] nl_dists [0:CAPACITY_DEF-1];
  int                nl_fill;
  logic [DIST_W-1:0] nl_bound;

  list_result_t due_results [$];
  plan_row_t    plan [$];

  int mismatches;
  int cycle_count;
  bit calm;
  bit hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic push_result(input status_t st, input int slot, input logic [31:0] eid,
                             input logic [31:0] edist, input bit last);
    list_result_t r;
    r.status     = st;
    r.slot       = slot[SLOT_W-1:0];
    r.filled     = nl_fill[FILLED_W-1:0];
    r.bound      = nl_bound;
    r.entry_id   = eid;
    r.entry_dist = edist;
    r.last       = last;
    due_results = {due_results, r};
  endtask

  // expected results of one accepted request; updates the list copy
  task automatic predict_list_step(input mode_t mode, input logic [31:0] id,
                                   input logic [31:0] cdist);
    int eff, n, i, l, j;
    bit dup;
    case (mode)
      MODE_INSERT: begin
        eff = int'(reg_capacity);
        if (eff < 1) eff = 1;
        if (eff > CAPACITY_DEF) eff = CAPACITY_DEF;
        if (nl_fill > eff) nl_fill = eff;  // capacity lowered: tail is cut
        if (cdist > nl_bound) begin
          push_result(ST_BEYOND, 0, '0, '0, 1'b1);
        end else begin
          n = nl_fill;
          i = n;
          while (i > 0 && nl_dists[i-1] > cdist) i--;
          // duplicate: same id among the equal-distance run just ahead
          l = i;
          dup = 1'b0;
          while (l > 0 && !dup && nl_dists[l-1] >= cdist) begin
            if (nl_ids[l-1] == id) dup = 1'b1;
            l--;
          end
          if (dup) begin
            push_result(ST_DUPLICATE, 0, '0, '0, 1'b1);
          end else if (n < eff) begin
            for (j = n; j > i; j--) begin
              nl_ids[j]   = nl_ids[j-1];
              nl_dists[j] = nl_dists[j-1];
            end
            nl_ids[i]   = id;
            nl_dists[i] = cdist;
            nl_fill     = n + 1;
            push_result(ST_INSERTED, i, '0, '0, 1'b1);
          end else begin
            // full: the tail falls off, bound follows the last kept entry
            if (i < n) begin
              for (j = n - 1; j > i; j--) begin
                nl_ids[j]   = nl_ids[j-1];
                nl_dists[j] = nl_dists[j-1];
              end
              nl_ids[i]   = id;
              nl_dists[i] = cdist;
            end
            nl_bound = nl_dists[n-1];
            if (i < n) push_result(ST_INSERTED, i, '0, '0, 1'b1);
            else push_result(ST_BEYOND, 0, '0, '0, 1'b1);
          end
        end
      end
      MODE_CLEAR: begin
        nl_fill  = 0;
        nl_bound = reg_radius;
        push_result(ST_CLEARED, 0, '0, '0, 1'b1);
      end
      MODE_DUMP: begin
        if (nl_fill == 0) push_result(ST_EMPTY, 0, '0, '0, 1'b1);
        for (j = 0; j < nl_fill && j < MAX_RESULTS; j++)
          push_result(ST_ENTRY, j, nl_ids[j], nl_dists[j], (j + 1 == nl_fill));
      end
      default: ;  // unused mode: nothing happens
    endcase
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic wait_idle();
    cand_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    wait_idle();
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_CAPACITY) reg_capacity = data[CAP_W-1:0];
    else reg_radius = data;
  endtask

  // offer one request; predict on acceptance, then maybe leave a gap
  task automatic send_request(input mode_t mode, input logic [31:0] id,
                              input logic [31:0] cdist, input bit typed,
                              input list_result_t known);
    int gap;
    cand_ch.mode      <= mode;
    cand_ch.cand_id   <= id;
    cand_ch.cand_dist <= cdist;
    cand_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cand_ch.ready);
    predict_list_step(mode, id, cdist);
    if (typed) due_results[due_results.size()-1] = known;
    gap = pick_gap();
    if (gap > 0) begin
      cand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic plan_row_t req(input mode_t m, input logic [31:0] id,
                                    input logic [31:0] cdist);
    plan_row_t p;
    p.kind    = STEP_REQ;
    p.mode    = m;
    p.reg_idx = REG_CAPACITY;
    p.id      = id;
    p.cdist   = cdist;
    p.typed   = 1'b0;
    p.known   = '0;
    return p;
  endfunction

  function automatic plan_row_t known(input mode_t m, input logic [31:0] id,
                                      input logic [31:0] cdist, input status_t st,
                                      input int slot, input int filled,
                                      input logic [31:0] bound);
    plan_row_t p;
    p = req(m, id, cdist);
    p.typed = 1'b1;
    p.known = '{st, slot[SLOT_W-1:0], filled[FILLED_W-1:0], bound, 32'd0, 32'd0, 1'b1};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] data);
    plan_row_t p;
    p = req(MODE_UNUSED, '0, data);
    p.kind    = STEP_CFG;
    p.reg_idx = idx;
    return p;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d", res_ch.status, res_ch.slot);
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(res_ch.status));
        check_field("slot", 32'(want.slot), 32'(res_ch.slot));
        check_field("filled", 32'(want.filled), 32'(res_ch.filled));
        check_field("bound", want.bound, res_ch.bound);
        check_field("entry_id", want.entry_id, res_ch.entry_id);
        check_field("entry_dist", want.entry_dist, res_ch.entry_dist);
        check_field("last", 32'(want.last), 32'(res_ch.last));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int sent, len, r, k;
    bit hold_done;
    logic [31:0] prev_id, prev_dist, id, cdist;
    mode_t m;

    mismatches = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    prev_id = '0;
    prev_dist = '0;
    rst = 1'b1;
    cand_ch.valid = 1'b0;
    cand_ch.mode = MODE_INSERT;
    cand_ch.cand_id = '0;
    cand_ch.cand_dist = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CAPACITY;
    cfg_ch.data = '0;
    reg_capacity = CAPACITY_RST;
    reg_radius = START_RADIUS_RST;
    nl_fill = 0;
    nl_bound = ALL1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    plan = '{
      known(MODE_DUMP,   0, 0,    ST_EMPTY,     0, 0, ALL1),
      known(MODE_INSERT, 5, ALL1, ST_INSERTED,  0, 1, ALL1),
      known(MODE_INSERT, 5, ALL1, ST_DUPLICATE, 0, 1, ALL1),
      known(MODE_INSERT, 7, 0,    ST_INSERTED,  0, 2, ALL1),
      req(MODE_INSERT, ALL1, 100),
      req(MODE_INSERT, 0, 100),      // equal distance goes behind
      req(MODE_INSERT, ALL1, 100),   // same id and distance ahead
      req(MODE_INSERT, 5, 100),      // same id, other distance
      req(MODE_DUMP, 0, 0),
      req(MODE_UNUSED, ALL1, ALL1),
      known(MODE_CLEAR,  0, 0,    ST_CLEARED,   0, 0, ALL1),
      cfg_row(REG_CAPACITY, 2),
      cfg_row(REG_START_RADIUS, 1000),
      known(MODE_CLEAR,  0, 0,    ST_CLEARED,   0, 0, 1000),
      known(MODE_INSERT, 1, 1001, ST_BEYOND,    0, 0, 1000),
      known(MODE_INSERT, 1, 1000, ST_INSERTED,  0, 1, 1000),
      req(MODE_INSERT, 2, 500),
      req(MODE_INSERT, 3, 700),      // full list, tail drops
      req(MODE_INSERT, 4, 900),
      req(MODE_INSERT, 5, 700),      // lands on the dropped tail
      req(MODE_DUMP, 0, 0),
      cfg_row(REG_CAPACITY, 1),      // lowered below the fill
      req(MODE_DUMP, 0, 0),
      req(MODE_INSERT, 9, 0),
      req(MODE_DUMP, 0, 0),
      cfg_row(REG_CAPACITY, 0),      // clamps up to one
      req(MODE_INSERT, 11, 0),
      cfg_row(REG_CAPACITY, 63),     // clamps down to the list size
      cfg_row(REG_START_RADIUS, 0),
      req(MODE_CLEAR, 0, 0),
      req(MODE_INSERT, 3, 0),
      req(MODE_INSERT, 4, 1)
    };
    foreach (plan[k]) begin
      if (plan[k].kind == STEP_CFG) write_reg(plan[k].reg_idx, plan[k].cdist);
      else send_request(plan[k].mode, plan[k].id, plan[k].cdist, plan[k].typed, plan[k].known);
    end

    // random phases: configure, clear, stream candidates, dump
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) write_reg(REG_CAPACITY, 0);
      else if (r < 20) write_reg(REG_CAPACITY, 63);
      else if (r < 28) write_reg(REG_CAPACITY, 32);
      else if (r < 35) write_reg(REG_CAPACITY, $urandom_range(0, 63));
      else write_reg(REG_CAPACITY, $urandom_range(1, 8));
      r = $urandom_range(0, 99);
      if (r < 40) write_reg(REG_START_RADIUS, ALL1);
      else if (r < 75) write_reg(REG_START_RADIUS, $urandom_range(20, 63));
      else if (r < 85) write_reg(REG_START_RADIUS, 0);
      else write_reg(REG_START_RADIUS, $urandom());
      send_request(MODE_CLEAR, $urandom(), $urandom(), 1'b0, '0);
      sent++;
      len = $urandom_range(4, 30);
      // one long hold-off on results while requests keep coming
      if (!hold_done && sent > 100) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
        len = 24;
      end
      repeat (len) begin
        r = $urandom_range(0, 99);
        m = MODE_INSERT;
        id = $urandom_range(0, 7);
        cdist = $urandom_range(0, 63);
        if (r < 65) begin
          if ($urandom_range(0, 4) == 0) cdist = nl_bound - $urandom_range(0, 2);
        end else if (r < 72) begin
          id = prev_id;
          cdist = prev_dist;
        end else if (r < 80) begin
          id = $urandom();
          cdist = $urandom();
        end else if (r < 88) begin
          m = MODE_DUMP;
        end else if (r < 93) begin
          m = MODE_CLEAR;
        end else begin
          m = MODE_UNUSED;
          id = $urandom();
          cdist = $urandom();
        end
        if (m == MODE_INSERT) begin
          prev_id = id;
          prev_dist = cdist;
        end
        send_request(m, id, cdist, 1'b0, '0);
        if (m != MODE_UNUSED) sent++;
      end
      send_request(MODE_DUMP, $urandom(), $urandom(), 1'b0, '0);
      sent++;
    end

    // drain and report
    cand_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
